// ===== sv/tmd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmd_pkg
// Types, event codes and the auxiliary-walk decision shared by the deframer.
// ----------------------------------------------------------------------------
package tmd_pkg;

   localparam int MaxEvents = 4;
   localparam int OffW = 21;

   localparam logic [2:0] EV_HDR  = 3'd0;
   localparam logic [2:0] EV_PHDR = 3'd1;
   localparam logic [2:0] EV_AUX  = 3'd2;
   localparam logic [2:0] EV_SEL  = 3'd3;
   localparam logic [2:0] EV_ERR  = 3'd4;
   localparam logic [2:0] EV_END  = 3'd5;

   localparam logic [1:0] ERR_SMALL    = 2'd0;
   localparam logic [1:0] ERR_MISMATCH = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

   localparam logic [31:0] AUX_OBJ = 32'd2;
   localparam logic [31:0] AUX_I32 = 32'd3;
   localparam logic [31:0] AUX_I64 = 32'd4;

   typedef struct packed {
      logic [2:0]      kind;
      logic [OffW-1:0] offset;
      logic [OffW-1:0] length;
      logic [1:0]      err;
      logic            ok;
   } tmd_event_type;

   typedef tmd_event_type [MaxEvents-1:0] tmd_list_type;

   typedef struct packed {
      logic         load;
      logic [2:0]   count;
      tmd_list_type events;
   } tmd_push_type;

   typedef struct packed {
      logic [1:0]          count;
      tmd_event_type [2:0] events;
      logic                done;
   } tmd_aux_type;

   function automatic tmd_event_type mk_ev(logic [2:0] kind, logic [OffW-1:0] off,
                                           logic [OffW-1:0] len, logic [1:0] err,
                                           logic ok);
      tmd_event_type e;
      e.kind = kind;
      e.offset = off;
      e.length = len;
      e.err = err;
      e.ok = ok;
      return e;
   endfunction

   // Decision taken each time the auxiliary cursor moves to a new item start.
   function automatic tmd_aux_type aux_next(logic [OffW-1:0] cur, logic [OffW-1:0] alen,
                                            logic [OffW-1:0] ovl, logic [OffW-1:0] total);
      tmd_aux_type r;
      logic [OffW+1:0] sum_end;
      r = '0;
      sum_end = {2'b00, ovl} + (OffW+2)'(48);
      if (cur > alen) begin
         r.count = 2'd2;
         r.events[0] = mk_ev(EV_ERR, '0, '0, ERR_UNKNOWN, 1'b0);
         r.events[1] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b0);
         r.done = 1'b1;
      end else if (cur < alen) begin
         if ({1'b0, alen} < {1'b0, cur} + (OffW+1)'(12)) begin
            r.count = 2'd3;
            r.events[0] = mk_ev(EV_ERR, '0, '0, ERR_SMALL, 1'b0);
            r.events[1] = mk_ev(EV_ERR, '0, '0, ERR_UNKNOWN, 1'b0);
            r.events[2] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b0);
            r.done = 1'b1;
         end
      end else if (ovl < alen) begin
         r.count = 2'd2;
         r.events[0] = mk_ev(EV_ERR, '0, '0, ERR_MISMATCH, 1'b0);
         r.events[1] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b0);
         r.done = 1'b1;
      end else begin
         r.events[0] = mk_ev(EV_SEL, alen + OffW'(48), ovl - alen, ERR_SMALL, 1'b0);
         r.done = 1'b1;
         if (sum_end != {2'b00, total}) begin
            r.count = 2'd3;
            r.events[1] = mk_ev(EV_ERR, '0, '0, ERR_MISMATCH, 1'b0);
            r.events[2] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b0);
         end else begin
            r.count = 2'd2;
            r.events[1] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b1);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/tmd_evq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmd_evq
// Result buffer that holds the events of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module tmd_evq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tmd_pkg::tmd_push_type push,
   output logic                       room,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [47:0]                rsp_tdata,  // offset, length, error, ok
   output logic [2:0]                 rsp_tuser,  // kind
   output logic                       rsp_tlast
);
   import tmd_pkg::*;

   tmd_list_type  list_ff;
   logic [2:0]    cnt_ff;
   logic [2:0]    idx_ff;
   tmd_event_type cur;
   logic          is_last;

   assign cur = list_ff[idx_ff[1:0]];
   assign rsp_tvalid = idx_ff != cnt_ff;
   assign is_last = idx_ff + 3'd1 == cnt_ff;
   assign rsp_tlast = is_last;
   assign rsp_tdata = {3'b000, cur.ok, cur.err, cur.length, cur.offset};
   assign rsp_tuser = cur.kind;
   assign room = !rsp_tvalid || (rsp_tready && is_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (push.load) begin
         cnt_ff <= push.count;
         idx_ff <= '0;
         list_ff <= push.events;
      end else if (rsp_tvalid && rsp_tready) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end
endmodule
`default_nettype wire

// ===== sv/tagged_message_deframer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_message_deframer_core
// Byte-serial deframer that reports the sections of a tagged message.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req      in         tdata: data_byte, message_length; tuser: starts_message
// rsp      out        tdata: offset, length, error, ok; tuser: event kind; tlast
//
// A request is parsed in the cycle it is accepted and its events land in a
// four-entry buffer. One event leaves per cycle while rsp_tready is high; a
// request that causes at most one event keeps the rate at one byte per cycle.
// Reset is synchronous and clears the parser and the buffer.
// req_tready is high while the buffer is empty or its last event leaves in the
// same cycle, so a stall on rsp holds req_tready low while any event waits.
module tagged_message_deframer_core #(
   parameter int MAX_MESSAGE_BYTES = 1048576
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // data_byte, message_length
   input  wire logic        req_tuser,  // starts_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // section_offset, section_length,
                                        // error_kind, parse_ok
   output logic [2:0]       rsp_tuser,  // event_kind
   output logic             rsp_tlast   // last_of_run
);
   import tmd_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_HDR, PH_PHDR, PH_AUXTYPE, PH_AUXLEN, PH_DONE
   } phase_type;

   localparam logic [24:0] MaxBytes = 25'(MAX_MESSAGE_BYTES);

   phase_type       phase_ff, phase_in;
   logic [OffW-1:0] off_ff, off_in, total_ff, total_in;
   logic [63:0]     shift_ff, shift_in;
   logic [31:0]     plen_ff, plen_in;
   logic [31:0]     alen_ff, alen_in;
   logic [OffW-1:0] ovl_ff, ovl_in, cur_ff, cur_in;

   logic            accept;
   logic            room;
   tmd_push_type    push;
   tmd_list_type    list;
   logic [2:0]      n;
   logic [OffW-1:0] ml, pos, room_len;
   logic [31:0]     v;
   logic [33:0]     item_end;
   tmd_aux_type     ax;
   logic            walk;
   logic [OffW-1:0] walk_cur;

   assign accept = req_tvalid && req_tready;
   assign req_tready = room;

   always_comb begin
      phase_in = phase_ff;
      off_in = off_ff;
      total_in = total_ff;
      shift_in = shift_ff;
      plen_in = plen_ff;
      alen_in = alen_ff;
      ovl_in = ovl_ff;
      cur_in = cur_ff;
      list = '0;
      n = '0;
      walk = 1'b0;
      walk_cur = '0;
      ml = req_tdata[28:8];
      pos = '0;
      v = '0;
      item_end = '0;
      room_len = '0;
      if ({4'd0, ml} > MaxBytes) begin
         ml = MaxBytes[OffW-1:0];
      end
      if (req_tuser) begin
         total_in = ml;
         off_in = '0;
         shift_in = '0;
         plen_in = '0;
         alen_in = '0;
         ovl_in = '0;
         cur_in = '0;
         phase_in = PH_HDR;
         if (ml < OffW'(32)) begin
            list[0] = mk_ev(EV_ERR, '0, '0, ERR_SMALL, 1'b0);
            list[1] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b0);
            n = 3'd2;
            phase_in = PH_DONE;
         end
      end
      if (n == 3'd0 && phase_in != PH_IDLE && phase_in != PH_DONE) begin
         if (off_in >= total_in) begin
            phase_in = PH_DONE;
         end else begin
            shift_in = {req_tdata[7:0], shift_in[63:8]};
            pos = off_in;
            off_in = off_in + OffW'(1);
            v = shift_in[63:32];
            room_len = total_in - OffW'(48);
            case (phase_in)
               PH_HDR: begin
                  if (pos == OffW'(15)) plen_in = v;
                  if (pos == OffW'(31)) begin
                     list[0] = mk_ev(EV_HDR, '0, OffW'(32), ERR_SMALL, 1'b0);
                     n = 3'd1;
                     if ({12'd0, total_in} < {1'b0, plen_in} + 33'd32
                         || total_in < OffW'(48)) begin
                        list[1] = mk_ev(EV_ERR, '0, '0, ERR_MISMATCH, 1'b0);
                        list[2] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b0);
                        n = 3'd3;
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_PHDR;
                     end
                  end
               end
               PH_PHDR: begin
                  if (pos == OffW'(39)) alen_in = v;
                  if (pos == OffW'(47)) begin
                     list[0] = mk_ev(EV_PHDR, OffW'(32), OffW'(16), ERR_SMALL, 1'b0);
                     n = 3'd1;
                     if (shift_in > {43'd0, room_len}
                         || alen_in > {11'd0, room_len}) begin
                        list[1] = mk_ev(EV_ERR, '0, '0, ERR_SMALL, 1'b0);
                        list[2] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b0);
                        n = 3'd3;
                        phase_in = PH_DONE;
                     end else begin
                        ovl_in = shift_in[OffW-1:0];
                        walk = 1'b1;
                        walk_cur = OffW'(16);
                     end
                  end
               end
               PH_AUXTYPE: begin
                  if ({1'b0, pos} == {1'b0, cur_ff} + (OffW+1)'(55)) begin
                     if (v == AUX_I32) begin
                        list[0] = mk_ev(EV_AUX, cur_ff + OffW'(48), OffW'(12),
                                        ERR_SMALL, 1'b0);
                        n = 3'd1;
                        walk = 1'b1;
                        walk_cur = cur_ff + OffW'(12);
                     end else if (v == AUX_I64) begin
                        if ({1'b0, alen_ff[OffW-1:0]} < {1'b0, cur_ff} + (OffW+1)'(16))
                        begin
                           list[0] = mk_ev(EV_ERR, '0, '0, ERR_SMALL, 1'b0);
                           list[1] = mk_ev(EV_ERR, '0, '0, ERR_UNKNOWN, 1'b0);
                           list[2] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b0);
                           n = 3'd3;
                           phase_in = PH_DONE;
                        end else begin
                           list[0] = mk_ev(EV_AUX, cur_ff + OffW'(48), OffW'(16),
                                           ERR_SMALL, 1'b0);
                           n = 3'd1;
                           walk = 1'b1;
                           walk_cur = cur_ff + OffW'(16);
                        end
                     end else if (v == AUX_OBJ) begin
                        phase_in = PH_AUXLEN;
                     end else begin
                        list[0] = mk_ev(EV_ERR, '0, '0, ERR_UNKNOWN, 1'b0);
                        list[1] = mk_ev(EV_ERR, '0, '0, ERR_UNKNOWN, 1'b0);
                        list[2] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b0);
                        n = 3'd3;
                        phase_in = PH_DONE;
                     end
                  end
               end
               PH_AUXLEN: begin
                  if ({1'b0, pos} == {1'b0, cur_ff} + (OffW+1)'(59)) begin
                     item_end = {13'd0, cur_ff} + 34'd12 + {2'd0, v};
                     if ({2'd0, alen_ff} < item_end) begin
                        list[0] = mk_ev(EV_ERR, '0, '0, ERR_SMALL, 1'b0);
                        list[1] = mk_ev(EV_ERR, '0, '0, ERR_UNKNOWN, 1'b0);
                        list[2] = mk_ev(EV_END, '0, '0, ERR_SMALL, 1'b0);
                        n = 3'd3;
                        phase_in = PH_DONE;
                     end else begin
                        list[0] = mk_ev(EV_AUX, cur_ff + OffW'(48),
                                        v[OffW-1:0] + OffW'(12), ERR_SMALL, 1'b0);
                        n = 3'd1;
                        walk = 1'b1;
                        walk_cur = item_end[OffW-1:0];
                     end
                  end
               end
               default: phase_in = PH_DONE;
            endcase
         end
      end
      ax = aux_next(walk_cur, alen_in[OffW-1:0], ovl_in, total_in);
      if (walk) begin
         cur_in = walk_cur;
         list[1] = ax.events[0];
         list[2] = ax.events[1];
         list[3] = ax.events[2];
         n = 3'd1 + {1'b0, ax.count};
         phase_in = ax.done ? PH_DONE : PH_AUXTYPE;
      end
   end

   always_comb begin
      push.load = accept;
      push.count = n;
      push.events = list;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         off_ff <= '0;
         total_ff <= '0;
         shift_ff <= '0;
         plen_ff <= '0;
         alen_ff <= '0;
         ovl_ff <= '0;
         cur_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         off_ff <= off_in;
         total_ff <= total_in;
         shift_ff <= shift_in;
         plen_ff <= plen_in;
         alen_ff <= alen_in;
         ovl_ff <= ovl_in;
         cur_ff <= cur_in;
      end
   end

   tmd_evq u_evq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_END |-> rsp_tlast)
      else $error("end event is not the last of its run");
   a_err_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_ERR |-> !rsp_tlast)
      else $error("error event closes a run");
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> !rsp_tvalid || (rsp_tready && rsp_tlast))
      else $error("request taken while events are still buffered");

endmodule
`default_nettype wire

// ===== tb/tagged_message_deframer_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_message_deframer_core_tb
// Self-checking bench for the byte-serial tagged message deframer.
// Messages are built as byte arrays, both well formed and damaged. They are
// streamed into the block under random idling and stalls. A local parser model
// predicts every section, error and end event, and the bench checks them in
// order against the response stream.
// ----------------------------------------------------------------------------
module tagged_message_deframer_core_tb;
   import tmd_pkg::*;

   localparam int MsgMax = 1048576;
   localparam int CycleLimit = 400000;
   localparam int ItemTarget = 230;
   localparam int CalmFrom = 250;
   localparam int CalmTo = 350;
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_HDR = 3'd1;
   localparam logic [2:0] PH_PHDR = 3'd2;
   localparam logic [2:0] PH_AUXTYPE = 3'd3;
   localparam logic [2:0] PH_AUXLEN = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;
   localparam logic [31:0] AUX_BAD = 32'd7;

   typedef struct {
      logic [7:0]  data;
      logic        start;
      logic [20:0] mlen;
      bit          pause;
   } byte_req_type;

   typedef struct {
      logic [2:0]  kind;
      logic [20:0] offset;
      logic [20:0] length;
      logic [1:0]  err;
      logic        ok;
      logic        last;
   } section_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   byte_req_type      byte_queue[$];
   section_event_type expected_events[$];
   logic [7:0]        msg_bytes[$];

   int unsigned cycles = 0;
   int unsigned errors = 0;
   int unsigned accepted = 0;
   int unsigned messages = 0;
   int unsigned events_seen = 0;
   int unsigned error_events = 0;
   int unsigned good_parses = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned build_total;

   // Parser state of the model.
   logic [20:0] pos_cnt = '0;
   logic [20:0] msg_total = '0;
   logic [2:0]  phase = PH_IDLE;
   logic [63:0] shreg = '0;
   logic [63:0] ovl = '0;
   logic [63:0] cursor = '0;
   logic [63:0] item_stop = '0;
   logic [31:0] plen = '0;
   logic [31:0] alen = '0;

   tagged_message_deframer_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #10 clock = ~clock;

   task automatic emit(logic [2:0] kind, logic [63:0] off, logic [63:0] len,
                       logic [1:0] err, logic ok);
      section_event_type e;
      e.kind = kind;
      e.offset = off[20:0];
      e.length = len[20:0];
      e.err = err;
      e.ok = ok;
      e.last = 1'b0;
      expected_events.push_back(e);
   endtask

   task automatic close_msg(logic ok);
      emit(EV_END, 64'd0, 64'd0, ERR_SMALL, ok);
      phase = PH_DONE;
   endtask

   task automatic fail_one(logic [1:0] err);
      emit(EV_ERR, 64'd0, 64'd0, err, 1'b0);
      close_msg(1'b0);
   endtask

   task automatic fail_aux(logic [1:0] err);
      emit(EV_ERR, 64'd0, 64'd0, err, 1'b0);
      emit(EV_ERR, 64'd0, 64'd0, ERR_UNKNOWN, 1'b0);
      close_msg(1'b0);
   endtask

   task automatic next_aux_item();
      logic [63:0] a;
      a = {32'd0, alen};
      if (cursor > a) begin
         fail_one(ERR_UNKNOWN);
      end else if (cursor < a) begin
         if (a < cursor + 64'd12) begin
            fail_aux(ERR_SMALL);
         end else begin
            phase = PH_AUXTYPE;
         end
      end else if (ovl < a) begin
         fail_one(ERR_MISMATCH);
      end else begin
         emit(EV_SEL, 64'd48 + a, ovl - a, ERR_SMALL, 1'b0);
         if (64'd48 + ovl != {43'd0, msg_total}) begin
            fail_one(ERR_MISMATCH);
         end else begin
            close_msg(1'b1);
         end
      end
   endtask

   task automatic predict_sections(byte_req_type r);
      int unsigned n0;
      logic [20:0] ml;
      logic [63:0] p, v;
      n0 = expected_events.size();
      if (r.start) begin
         ml = (r.mlen > MsgMax) ? 21'(MsgMax) : r.mlen;
         msg_total = ml;
         pos_cnt = '0;
         shreg = '0;
         plen = '0;
         alen = '0;
         ovl = '0;
         cursor = '0;
         item_stop = '0;
         phase = PH_HDR;
         if (msg_total < 21'd32) fail_one(ERR_SMALL);
      end
      if (!(r.start && msg_total < 21'd32) && phase != PH_IDLE && phase != PH_DONE) begin
         if (pos_cnt >= msg_total) begin
            phase = PH_DONE;
         end else begin
            shreg = {r.data, shreg[63:8]};
            p = {43'd0, pos_cnt};
            pos_cnt = pos_cnt + 21'd1;
            v = {32'd0, shreg[63:32]};
            case (phase)
               PH_HDR: begin
                  if (p == 64'd15) plen = v[31:0];
                  if (p == 64'd31) begin
                     emit(EV_HDR, 64'd0, 64'd32, ERR_SMALL, 1'b0);
                     if ({43'd0, msg_total} < 64'd32 + {32'd0, plen} || msg_total < 21'd48)
                        fail_one(ERR_MISMATCH);
                     else
                        phase = PH_PHDR;
                  end
               end
               PH_PHDR: begin
                  if (p == 64'd39) alen = v[31:0];
                  if (p == 64'd47) begin
                     ovl = shreg;
                     emit(EV_PHDR, 64'd32, 64'd16, ERR_SMALL, 1'b0);
                     if (ovl > {43'd0, msg_total} - 64'd48 ||
                         {32'd0, alen} > {43'd0, msg_total} - 64'd48) begin
                        fail_one(ERR_SMALL);
                     end else begin
                        cursor = 64'd16;
                        next_aux_item();
                     end
                  end
               end
               PH_AUXTYPE: begin
                  if (p == 64'd55 + cursor) begin
                     if (v == {32'd0, AUX_I32}) begin
                        item_stop = cursor + 64'd12;
                        emit(EV_AUX, 64'd48 + cursor, 64'd12, ERR_SMALL, 1'b0);
                        cursor = item_stop;
                        next_aux_item();
                     end else if (v == {32'd0, AUX_I64}) begin
                        item_stop = cursor + 64'd16;
                        if ({32'd0, alen} < item_stop) begin
                           fail_aux(ERR_SMALL);
                        end else begin
                           emit(EV_AUX, 64'd48 + cursor, 64'd16, ERR_SMALL, 1'b0);
                           cursor = item_stop;
                           next_aux_item();
                        end
                     end else if (v == {32'd0, AUX_OBJ}) begin
                        phase = PH_AUXLEN;
                     end else begin
                        fail_aux(ERR_UNKNOWN);
                     end
                  end
               end
               PH_AUXLEN: begin
                  if (p == 64'd59 + cursor) begin
                     item_stop = cursor + 64'd12 + v;
                     if ({32'd0, alen} < item_stop) begin
                        fail_aux(ERR_SMALL);
                     end else begin
                        emit(EV_AUX, 64'd48 + cursor, 64'd12 + v, ERR_SMALL, 1'b0);
                        cursor = item_stop;
                        next_aux_item();
                     end
                  end
               end
               default: phase = PH_DONE;
            endcase
         end
      end
      if (expected_events.size() > n0)
         expected_events[expected_events.size() - 1].last = 1'b1;
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
      errors++;
   endtask

   // Driver: presents queued bytes and feeds every accepted request to the model.
   always @(posedge clock) begin
      bit           idle;
      bit           take;
      byte_req_type nx;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            byte_req_type cur;
            cur.data = req_tdata[7:0];
            cur.start = req_tuser;
            cur.mlen = req_tdata[28:8];
            cur.pause = 1'b0;
            predict_sections(cur);
            accepted++;
            if (cur.start) messages++;
         end
         if (!req_tvalid || req_tready) begin
            idle = !(cycles >= CalmFrom && cycles < CalmTo) && $urandom_range(99) < 9;
            take = byte_queue.size() != 0 && !idle &&
                   !(byte_queue[0].pause && expected_events.size() != 0);
            if (take) begin
               nx = byte_queue.pop_front();
               req_tdata <= {3'd0, nx.mlen, nx.data};
               req_tuser <= nx.start;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side: random stalls, one long hold-off, and in-order checking.
   always @(posedge clock) begin
      section_event_type e;
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end else if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            events_seen++;
            if (expected_events.size() == 0) begin
               report_mismatch("unexpected event", 64'(rsp_tdata), 64'd0);
            end else begin
               e = expected_events.pop_front();
               if (e.kind == EV_ERR) error_events++;
               if (e.kind == EV_END && e.ok) good_parses++;
               if (rsp_tuser != e.kind)
                  report_mismatch("kind", 64'(rsp_tuser), 64'(e.kind));
               if (rsp_tdata[20:0] != e.offset)
                  report_mismatch("offset", 64'(rsp_tdata[20:0]), 64'(e.offset));
               if (rsp_tdata[41:21] != e.length)
                  report_mismatch("length", 64'(rsp_tdata[41:21]), 64'(e.length));
               if (rsp_tdata[43:42] != e.err)
                  report_mismatch("error", 64'(rsp_tdata[43:42]), 64'(e.err));
               if (rsp_tdata[44] != e.ok)
                  report_mismatch("ok", 64'(rsp_tdata[44]), 64'(e.ok));
               if (rsp_tlast != e.last)
                  report_mismatch("last", 64'(rsp_tlast), 64'(e.last));
            end
         end
         if (!hold_done && accepted >= 120) begin
            hold_done <= 1'b1;
            hold_left <= 80;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (cycles >= CalmFrom && cycles < CalmTo) || $urandom_range(99) >= 9;
         end
      end
   end

   task automatic put_le(int unsigned at, logic [63:0] val, int nb);
      for (int i = 0; i < nb; i++)
         if (at + i < msg_bytes.size()) msg_bytes[at + i] = val[8*i +: 8];
   endtask

   // Builds a well-formed message with the given auxiliary items into msg_bytes.
   task automatic build_msg(int cnt, logic [31:0] t0, logic [31:0] t1, logic [31:0] t2,
                            int unsigned objlen, int unsigned sel);
      logic [31:0] ty[3];
      int unsigned cur, alen_b, sz;
      ty[0] = t0;
      ty[1] = t1;
      ty[2] = t2;
      cur = 16;
      for (int k = 0; k < cnt; k++)
         cur += (ty[k] == AUX_I32) ? 12 : (ty[k] == AUX_I64) ? 16 : 12 + objlen;
      alen_b = cur;
      build_total = 48 + alen_b + sel;
      msg_bytes.delete();
      repeat (build_total) msg_bytes.push_back(8'($urandom));
      put_le(12, 64'(build_total - 32), 4);
      put_le(36, 64'(alen_b), 4);
      put_le(40, 64'(alen_b + sel), 8);
      cur = 16;
      for (int k = 0; k < cnt; k++) begin
         sz = (ty[k] == AUX_I32) ? 12 : (ty[k] == AUX_I64) ? 16 : 12 + objlen;
         put_le(52 + cur, 64'(ty[k]), 4);
         if (ty[k] == AUX_OBJ) put_le(56 + cur, 64'(objlen), 4);
         cur += sz;
      end
   endtask

   task automatic send_msg(logic [20:0] lenfield, bit pause, int unsigned nbytes);
      byte_req_type r;
      for (int unsigned i = 0; i < nbytes; i++) begin
         r.data = (i < msg_bytes.size()) ? msg_bytes[i] : 8'($urandom);
         r.start = (i == 0);
         r.mlen = (i == 0) ? lenfield : 21'($urandom);
         r.pause = pause && (i == 0);
         byte_queue.push_back(r);
      end
   endtask

   function automatic logic [31:0] pick_type();
      int unsigned s;
      s = $urandom_range(2);
      return (s == 0) ? AUX_I32 : (s == 1) ? AUX_I64 : AUX_OBJ;
   endfunction

   initial begin
      int unsigned sel, cut;
      msg_bytes.delete();
      repeat (3) msg_bytes.push_back(8'($urandom));
      send_msg(21'd200, 1'b0, 3);
      byte_queue[0].start = 1'b0;
      send_msg(21'd0, 1'b0, 1);
      send_msg(21'd31, 1'b0, 2);
      build_msg(3, AUX_I32, AUX_I64, AUX_OBJ, 2, 1);
      send_msg(21'(build_total), 1'b1, build_total);
      build_msg(0, AUX_I32, AUX_I32, AUX_I32, 0, 1);
      send_msg(21'h1FFFFF, 1'b0, 48);
      put_le(12, 64'hFFFFFFFF, 4);
      send_msg(21'(build_total), 1'b0, 33);

      while (byte_queue.size() < ItemTarget) begin
         sel = $urandom_range(6);
         build_msg($urandom_range(3), pick_type(), pick_type(), pick_type(),
                   $urandom_range(6), sel);
         case ($urandom_range(9))
            6: begin
               case ($urandom_range(3))
                  0: put_le($urandom_range(12, 15), 64'($urandom), 1);
                  1: put_le($urandom_range(36, 47), 64'($urandom), 1);
                  2: put_le(68, 64'($urandom_range(5)), 4);
                  default: put_le(72, 64'($urandom), 4);
               endcase
               send_msg(21'(build_total), $urandom_range(19) == 0, build_total);
            end
            7: begin
               cut = $urandom_range(1, 4);
               send_msg(21'(build_total + cut), 1'b0, build_total + cut);
            end
            8: begin
               send_msg(21'(build_total), 1'b0, $urandom_range(1, build_total));
            end
            9: begin
               send_msg(21'(build_total), 1'b0, build_total);
               repeat ($urandom_range(1, 3)) begin
                  msg_bytes.delete();
                  msg_bytes.push_back(8'($urandom));
                  send_msg(21'($urandom), 1'b0, 1);
                  byte_queue[byte_queue.size() - 1].start = 1'b0;
               end
            end
            default: send_msg(21'(build_total), $urandom_range(19) == 0, build_total);
         endcase
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (byte_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Streamed %0d bytes in %0d messages, checked %0d events.",
               accepted, messages, events_seen);
      $display("Saw %0d error events and %0d complete parses.", error_events, good_parses);
      if (errors == 0 && expected_events.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
